// File: rtl/sdte_pkg.sv
package sdte_pkg;

  localparam logic signed [31:0] TAG_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] TAG_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] tag_value;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic signed [31:0] distinct_value;
    logic               last_value;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic init;
    logic cmp;
  } scan_ctl_t;

endpackage

// File: rtl/sdte_store.sv
module sdte_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/sdte_scan_unit.sv
module sdte_scan_unit (
  input  logic                     clk,
  input  sdte_pkg::scan_ctl_t      ctl,
  input  logic signed [31:0]       prev,
  input  logic signed [31:0]       data,
  output logic signed [31:0]       best_r
);

  import sdte_pkg::*;

  logic signed [31:0] best_nxt;

  always_comb begin
    best_nxt = best_r;
    if (ctl.init) begin
      best_nxt = TAG_MAX;
    end else if (ctl.cmp && (data > prev) && (data < best_r)) begin
      best_nxt = data;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

endmodule

// File: rtl/sorted_distinct_tag_extractor.sv
// Loads a list of signed 32-bit tags, one per transaction, until a transaction
// marked last_item arrives; the block then emits every distinct tag once in
// ascending order, flagging the largest with last_value. Up to STORE_DEPTH
// tags are kept; further ones are dropped and every result of that run shows
// overflow. The most negative and most positive 32-bit values are stored but
// never emitted. During loading in_ready stays high, so a tag is accepted
// whenever in_valid is high. Extraction runs one pass of a single shared
// compare unit over the store per distinct value, plus a final pass that
// finds none left, reading one entry a cycle through the store's read port.
// in_ready rises again after the final pass. A finished pass waits while
// the result register holds a result not yet taken. A result register
// decouples the output, so a pass continues while a result waits to be taken.
module sorted_distinct_tag_extractor #(
  parameter int STORE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sdte_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sdte_pkg::out_t out_data
);

  import sdte_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               ovf_r, ovf_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic               rd_vld_r;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] pend_r, pend_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_t               out_r, out_nxt;

  logic               in_acc;
  logic               has_room;
  logic               wr_en;
  logic               rd_en;
  logic               out_free;
  logic               none_left;
  logic [31:0]        rd_data;
  logic signed [31:0] best;
  scan_ctl_t          ctl;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign has_room  = (fill_r < FW'(STORE_DEPTH));
  assign wr_en     = in_acc && has_room;
  assign rd_en     = (state_r == ST_SCAN);
  assign out_free  = !out_vld_r || out_ready;
  assign none_left = (best == TAG_MAX);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign ctl.init = (state_r == ST_SCAN) && (rd_addr_r == '0);
  assign ctl.cmp  = rd_vld_r;

  sdte_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (fill_r[AW-1:0]),
    .wr_data   (in_data.tag_value),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr_r),
    .rd_data_r (rd_data)
  );

  sdte_scan_unit u_scan (
    .clk    (clk),
    .ctl    (ctl),
    .prev   (prev_r),
    .data   ($signed(rd_data)),
    .best_r (best)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    rd_addr_nxt  = rd_addr_r;
    prev_nxt     = prev_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            fill_nxt = fill_r + FW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            state_nxt    = ST_SCAN;
            rd_addr_nxt  = '0;
            prev_nxt     = TAG_MIN;
            pend_vld_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (rd_addr_r == AW'(fill_r - FW'(1))) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt            = 1'b1;
            out_nxt.distinct_value = pend_r;
            out_nxt.last_value     = none_left;
            out_nxt.overflow       = ovf_r;
          end
          if (none_left) begin
            state_nxt    = ST_LOAD;
            fill_nxt     = '0;
            ovf_nxt      = 1'b0;
            prev_nxt     = TAG_MIN;
            pend_vld_nxt = 1'b0;
          end else begin
            state_nxt    = ST_SCAN;
            rd_addr_nxt  = '0;
            prev_nxt     = best;
            pend_nxt     = best;
            pend_vld_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      prev_r     <= TAG_MIN;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      ovf_r      <= ovf_nxt;
      rd_vld_r   <= rd_en;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      prev_r     <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

endmodule
